// ===== design/wdt_pkg.sv =====
package wdt_pkg;

  // field widths
  localparam int CMD_W    = 2;
  localparam int ID_W     = 32;
  localparam int DUR_W    = 32;
  localparam int STATUS_W = 3;
  localparam int OCC_OUT_W = 5;

  // packed stream widths
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 40;

  // results reported per tick at most
  localparam int MAX_RESULTS = 16;

  // command codes
  localparam logic [CMD_W-1:0] CMD_REGISTER   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_EXTEND     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DEREGISTER = 2'd2;
  localparam logic [CMD_W-1:0] CMD_TICK       = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_REFUSED   = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_EXPIRED   = 3'd4;
  localparam logic [STATUS_W-1:0] STAT_NONE      = 3'd5;

  // one table word: {extended, remaining, ident}
  typedef struct packed {
    logic             extended;
    logic [DUR_W-1:0] remaining;
    logic [ID_W-1:0]  ident;
  } slot_word_t;

endpackage

// ===== design/watchdog_timeout_table_core.sv =====
// Watchdog timeout table: tracks up to ENTRIES identifiers, each with a remaining
// tick count and a one-shot extension flag. Every command walks the whole table
// through the slot memory, one slot per cycle. Register, extend and deregister
// pass through accept, the scan, one update step and the loading of the result;
// a tick has no update step and loads one result per expired entry it reports;
// a result waits in the emit step while m_tready holds off the previous one.
// s_tready is high only while no item is in work. Register, extend and deregister
// give one result; a tick gives one result per expired entry (at most 16, lowest
// slots first) or a single no-expiry result, and m_tlast marks the final one.
// The table needs no clearing after reset.
module watchdog_timeout_table_core #(
  parameter int ENTRIES = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration: default timeout
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [wdt_pkg::DUR_W-1:0]        cfg_data,
  // input items
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [wdt_pkg::IN_TDATA_W-1:0]   s_tdata,   // command, ident, duration, zero pad
  // result items
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [wdt_pkg::OUT_TDATA_W-1:0]  m_tdata,   // status, entry_ident, occupancy
  output logic                             m_tlast
);
  import wdt_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W = $clog2(ENTRIES + 1);
  localparam int RES_W = $clog2(MAX_RESULTS);
  localparam int CNT_W = RES_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  // sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0]          state;
  logic [DUR_W-1:0]    dflt_ticks;
  logic [ENTRIES-1:0]  slot_valid;
  logic [OCC_W-1:0]    occ;

  // latched item
  logic [CMD_W-1:0]    cmd;
  logic [ID_W-1:0]     ident;
  logic [DUR_W-1:0]    duration;

  // scan pointer and read pipeline
  logic [IDX_W-1:0]    scan_idx;
  logic                issue_done;
  logic                rd_pend;
  logic [IDX_W-1:0]    rd_slot;
  slot_word_t          rd_data;

  // lookup results
  logic                hit_found;
  logic [IDX_W-1:0]    hit_slot;
  logic                hit_ext;
  logic                free_found;
  logic [IDX_W-1:0]    free_slot;
  logic [STATUS_W-1:0] res_status;

  // expiry buffer
  logic [ID_W-1:0]     exp_buf [MAX_RESULTS];
  logic [CNT_W-1:0]    exp_cnt;
  logic [CNT_W-1:0]    emit_idx;

  // slot memory
  slot_word_t          slot_mem [ENTRIES];
  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  slot_word_t          mem_wdata;

  logic                is_tick;
  logic                proc;
  logic                cur_valid;
  logic [DUR_W-1:0]    rem_dec;
  logic                tick_exp;
  logic                scan_end;
  logic                item_acc;

  // apply step
  logic                apply_we;
  logic [IDX_W-1:0]    apply_slot;
  slot_word_t          apply_word;
  logic [STATUS_W-1:0] apply_status;
  logic                apply_set;
  logic                apply_clr;
  logic [DUR_W-1:0]    reg_timeout;

  // result output
  logic                out_load;
  logic                out_last;
  logic [STATUS_W-1:0] out_status;
  logic [ID_W-1:0]     out_ident;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign item_acc  = s_tvalid && s_tready;
  assign is_tick   = (cmd == CMD_TICK);

  // scan datapath: one slot per cycle
  assign proc      = (state == S_SCAN) && rd_pend;
  assign cur_valid = slot_valid[rd_slot];
  assign rem_dec   = (rd_data.remaining == '0) ? '0 : rd_data.remaining - DUR_W'(1);
  assign tick_exp  = proc && is_tick && cur_valid && (rem_dec == '0) &&
                     (exp_cnt < CNT_W'(MAX_RESULTS));
  assign scan_end  = proc && (rd_slot == LAST_IDX);

  // update step for register, extend and deregister
  assign reg_timeout = (duration == '0) ? dflt_ticks : duration;
  always_comb begin
    apply_we     = 1'b0;
    apply_slot   = hit_slot;
    apply_word   = '{extended: 1'b0, remaining: reg_timeout, ident: ident};
    apply_status = STAT_OK;
    apply_set    = 1'b0;
    apply_clr    = 1'b0;
    case (cmd)
      CMD_REGISTER: begin
        if (hit_found) begin
          apply_we = 1'b1;
        end else if (free_found) begin
          apply_we   = 1'b1;
          apply_slot = free_slot;
          apply_set  = 1'b1;
        end else begin
          apply_status = STAT_FULL;
        end
      end
      CMD_EXTEND: begin
        apply_word = '{extended: 1'b1, remaining: duration, ident: ident};
        if (!hit_found) begin
          apply_status = STAT_NOT_FOUND;
        end else if (hit_ext) begin
          apply_status = STAT_REFUSED;
        end else begin
          apply_we = 1'b1;
        end
      end
      CMD_DEREGISTER: begin
        if (!hit_found) begin
          apply_status = STAT_NOT_FOUND;
        end else begin
          apply_clr = 1'b1;
        end
      end
      default: begin
        apply_status = STAT_OK;
      end
    endcase
  end

  // memory write port
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = rd_slot;
    mem_wdata = '{extended: rd_data.extended, remaining: rem_dec, ident: rd_data.ident};
    if (proc && is_tick && cur_valid) begin
      mem_we = 1'b1;
    end else if (state == S_APPLY) begin
      mem_we    = apply_we;
      mem_waddr = apply_slot;
      mem_wdata = apply_word;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
    if (state == S_SCAN && !issue_done) begin
      rd_data <= slot_mem[scan_idx];
    end
  end

  // result selection
  assign out_load   = (state == S_EMIT) && (!m_tvalid || m_tready);
  assign out_last   = !is_tick || (exp_cnt == '0) || (emit_idx == exp_cnt - CNT_W'(1));
  always_comb begin
    out_status = res_status;
    out_ident  = ident;
    if (is_tick) begin
      if (exp_cnt == '0) begin
        out_status = STAT_NONE;
        out_ident  = '0;
      end else begin
        out_status = STAT_EXPIRED;
        out_ident  = exp_buf[emit_idx[RES_W-1:0]];
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      dflt_ticks <= DUR_W'(25);
      slot_valid <= '0;
      occ        <= '0;
      m_tvalid   <= 1'b0;
      issue_done <= 1'b0;
      rd_pend    <= 1'b0;
      exp_cnt    <= '0;
      emit_idx   <= '0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        dflt_ticks <= cfg_data;
      end
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_acc) begin
            state      <= S_SCAN;
            issue_done <= 1'b0;
            rd_pend    <= 1'b0;
            exp_cnt    <= '0;
            emit_idx   <= '0;
            hit_found  <= 1'b0;
            free_found <= 1'b0;
          end
        end
        S_SCAN: begin
          rd_pend <= !issue_done;
          if (!issue_done && scan_idx == LAST_IDX) begin
            issue_done <= 1'b1;
          end
          if (proc) begin
            if (cur_valid && rd_data.ident == ident && !hit_found) begin
              hit_found <= 1'b1;
            end
            if (!cur_valid && !free_found) begin
              free_found <= 1'b1;
            end
          end
          if (tick_exp) begin
            slot_valid[rd_slot] <= 1'b0;
            occ                 <= occ - OCC_W'(1);
            exp_cnt             <= exp_cnt + CNT_W'(1);
          end
          if (scan_end) begin
            state <= is_tick ? S_EMIT : S_APPLY;
          end
        end
        S_APPLY: begin
          if (apply_set) begin
            slot_valid[apply_slot] <= 1'b1;
            occ                    <= occ + OCC_W'(1);
          end
          if (apply_clr) begin
            slot_valid[apply_slot] <= 1'b0;
            occ                    <= occ - OCC_W'(1);
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_load) begin
            m_tvalid <= 1'b1;
            emit_idx <= emit_idx + CNT_W'(1);
            if (out_last) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (item_acc) begin
      cmd      <= s_tdata[CMD_W-1:0];
      ident    <= s_tdata[CMD_W +: ID_W];
      duration <= s_tdata[CMD_W + ID_W +: DUR_W];
      scan_idx <= '0;
    end else if (state == S_SCAN && !issue_done && scan_idx != LAST_IDX) begin
      scan_idx <= scan_idx + IDX_W'(1);
    end
    if (state == S_SCAN && !issue_done) begin
      rd_slot <= scan_idx;
    end
    if (proc && cur_valid && rd_data.ident == ident && !hit_found) begin
      hit_slot <= rd_slot;
      hit_ext  <= rd_data.extended;
    end
    if (proc && !cur_valid && !free_found) begin
      free_slot <= rd_slot;
    end
    if (tick_exp) begin
      exp_buf[exp_cnt[RES_W-1:0]] <= rd_data.ident;
    end
    if (state == S_APPLY) begin
      res_status <= apply_status;
    end
    if (out_load) begin
      m_tdata <= {OCC_OUT_W'(occ), out_ident, out_status};
      m_tlast <= out_last;
    end
  end

endmodule
